[design/stl_pkg.sv]
// stl_pkg: shared constants for the steering torque limiter
// field widths, stream packing offsets, register indexes and reset values
// no dependencies
package stl_pkg;

    // fixed-point format of the torque command
    localparam int CMD_FRAC_BITS = 4;
    localparam int CMD_W         = 20;

    // sample window
    localparam int WINDOW_DEPTH  = 6;

    // measurement frame fields
    localparam int FRAME_ID_W    = 11;
    localparam int BUS_W         = 3;
    localparam int LEN_W         = 4;
    localparam int TORQUE_W      = 16;
    localparam logic [FRAME_ID_W-1:0] FRAME_ID_MATCH = 11'h260;
    localparam logic [BUS_W-1:0]      BUS_MATCH      = 3'd0;
    localparam logic [LEN_W-1:0]      LEN_MATCH      = 4'd8;

    // measured torque scaling by eps_factor / 100
    localparam int EPS_W         = 8;
    localparam int PROD_W        = TORQUE_W + EPS_W + 1;
    localparam int MAG_W         = PROD_W - 2;
    // divide by 100 as multiply by ceil(2^30 / 100), exact for magnitudes below 2^23
    localparam int RECIP_SHIFT   = 30;
    localparam int RECIP_W       = 24;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
    localparam int QUOT_W        = 17;
    localparam int SAMPLE_W      = 18;

    // result fields
    localparam int APPLIED_W     = 16;

    // internal width for the clamp arithmetic in command units
    localparam int CALC_BASE     = (CMD_W > 17 + CMD_FRAC_BITS) ? CMD_W : 17 + CMD_FRAC_BITS;
    localparam int CALC_W        = CALC_BASE + 2;

    // limit registers
    localparam int RATE_W        = 12;
    localparam int LIMIT_W       = 15;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 15;

    localparam logic [CFG_ADDR_W-1:0] REG_EPS_FACTOR   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE_UP      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE_DOWN    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ERROR_LIMIT  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TORQUE_LIMIT = 3'd4;

    localparam logic [EPS_W-1:0]   EPS_FACTOR_RST   = 8'd73;
    localparam logic [RATE_W-1:0]  RATE_UP_RST      = 12'd10;
    localparam logic [RATE_W-1:0]  RATE_DOWN_RST    = 12'd20;
    localparam logic [LIMIT_W-1:0] ERROR_LIMIT_RST  = 15'd350;
    localparam logic [LIMIT_W-1:0] TORQUE_LIMIT_RST = 15'd1500;

    // operation codes carried in s_tuser
    localparam logic OP_FRAME   = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    // input tdata packing
    localparam int S_ID_LSB      = 0;
    localparam int S_BUS_LSB     = S_ID_LSB + FRAME_ID_W;
    localparam int S_LEN_LSB     = S_BUS_LSB + BUS_W;
    localparam int S_TORQUE_LSB  = S_LEN_LSB + LEN_W;
    localparam int S_CMD_LSB     = S_TORQUE_LSB + TORQUE_W;
    localparam int S_USED_W      = S_CMD_LSB + CMD_W;
    localparam int S_TDATA_W     = ((S_USED_W + 7) / 8) * 8;

    // output tdata packing
    localparam int M_APPLIED_LSB = 0;
    localparam int M_MEAS_LSB    = M_APPLIED_LSB + APPLIED_W;
    localparam int M_MIN_LSB     = M_MEAS_LSB + SAMPLE_W;
    localparam int M_MAX_LSB     = M_MIN_LSB + SAMPLE_W;
    localparam int M_USED_W      = M_MAX_LSB + SAMPLE_W;
    localparam int M_TDATA_W     = ((M_USED_W + 7) / 8) * 8;

endpackage

[design/steering_torque_limiter_core.sv]
// steering_torque_limiter_core: measured-torque window and command clamp/rate limiter
// three-stage pipeline plus output register
// depends on stl_pkg
//
// path: an item taken into s0 moves through s1 and s2; a command then fills the output
//   register, while a frame gives no result and updates the window at the commit stage
// throughput: one item per cycle unless stalled; s2 holds window and last applied value
// reset: aresetn synchronous, active low; limit registers back to defaults, window, marks,
//   last applied value and all valid flags cleared
module steering_torque_limiter_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // frame_id, bus_index, data_length, torque_raw, command, zero pad
    input  logic [stl_pkg::S_TDATA_W-1:0]       s_tdata,
    // operation
    input  logic [0:0]                          s_tuser,
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // applied_torque, measured_torque, window_min, window_max, zero pad
    output logic [stl_pkg::M_TDATA_W-1:0]       m_tdata,
    // limited
    output logic [0:0]                          m_tuser,
    // limit register writes
    input  logic                                cfg_wr_en,
    input  logic [stl_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [stl_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);

    localparam int CW = stl_pkg::CALC_W;
    localparam int F  = stl_pkg::CMD_FRAC_BITS;
    // half of one command unit, zero when there are no fraction bits
    localparam logic [CW-1:0] HALF = CW'((1 << F) >> 1);

    typedef enum logic {KIND_FRAME, KIND_CMD} item_kind_t;
    typedef logic signed [CW-1:0] calc_t;

    function automatic calc_t smin(input calc_t a, input calc_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic calc_t smax(input calc_t a, input calc_t b);
        return (a > b) ? a : b;
    endfunction

    // ---------------------------------------------------------------
    // limit registers
    // ---------------------------------------------------------------
    logic [stl_pkg::EPS_W-1:0]   eps_factor_reg;
    logic [stl_pkg::RATE_W-1:0]  rate_up_reg;
    logic [stl_pkg::RATE_W-1:0]  rate_down_reg;
    logic [stl_pkg::LIMIT_W-1:0] error_limit_reg;
    logic [stl_pkg::LIMIT_W-1:0] torque_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_factor_reg   <= stl_pkg::EPS_FACTOR_RST;
            rate_up_reg      <= stl_pkg::RATE_UP_RST;
            rate_down_reg    <= stl_pkg::RATE_DOWN_RST;
            error_limit_reg  <= stl_pkg::ERROR_LIMIT_RST;
            torque_limit_reg <= stl_pkg::TORQUE_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                stl_pkg::REG_EPS_FACTOR:   eps_factor_reg   <= cfg_wr_data[stl_pkg::EPS_W-1:0];
                stl_pkg::REG_RATE_UP:      rate_up_reg      <= cfg_wr_data[stl_pkg::RATE_W-1:0];
                stl_pkg::REG_RATE_DOWN:    rate_down_reg    <= cfg_wr_data[stl_pkg::RATE_W-1:0];
                stl_pkg::REG_ERROR_LIMIT:  error_limit_reg  <= cfg_wr_data;
                stl_pkg::REG_TORQUE_LIMIT: torque_limit_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // input field unpacking and frame filter
    // ---------------------------------------------------------------
    logic [stl_pkg::FRAME_ID_W-1:0]   in_frame_id;
    logic [stl_pkg::BUS_W-1:0]        in_bus_index;
    logic [stl_pkg::LEN_W-1:0]        in_data_length;
    logic signed [stl_pkg::TORQUE_W-1:0] in_torque;
    logic signed [stl_pkg::CMD_W-1:0] in_command;
    logic                             in_is_cmd;
    logic                             in_frame_ok;
    logic                             s_accept;

    assign in_frame_id    = s_tdata[stl_pkg::S_BUS_LSB-1:stl_pkg::S_ID_LSB];
    assign in_bus_index   = s_tdata[stl_pkg::S_LEN_LSB-1:stl_pkg::S_BUS_LSB];
    assign in_data_length = s_tdata[stl_pkg::S_TORQUE_LSB-1:stl_pkg::S_LEN_LSB];
    assign in_torque      = s_tdata[stl_pkg::S_CMD_LSB-1:stl_pkg::S_TORQUE_LSB];
    assign in_command     = s_tdata[stl_pkg::S_USED_W-1:stl_pkg::S_CMD_LSB];
    assign in_is_cmd      = (s_tuser[0] == stl_pkg::OP_COMMAND);
    assign in_frame_ok    = (in_frame_id == stl_pkg::FRAME_ID_MATCH)
                         && (in_bus_index == stl_pkg::BUS_MATCH)
                         && (in_data_length == stl_pkg::LEN_MATCH);
    assign s_accept       = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // pipeline registers
    // s0: input register, s1: scaled product, s2: commit stage
    // ---------------------------------------------------------------
    logic                                  s0_valid_reg, s1_valid_reg, s2_valid_reg;
    item_kind_t                            s0_kind_reg, s1_kind_reg, s2_kind_reg;
    logic signed [stl_pkg::TORQUE_W-1:0]   s0_torque_reg;
    logic signed [stl_pkg::CMD_W-1:0]      s0_cmd_reg, s1_cmd_reg, s2_cmd_reg;
    logic signed [stl_pkg::PROD_W-1:0]     s1_prod_reg;
    logic signed [stl_pkg::SAMPLE_W-1:0]   s2_sample_reg;
    calc_t                                 s2_val_reg;

    // state
    logic signed [stl_pkg::SAMPLE_W-1:0]   window_reg [stl_pkg::WINDOW_DEPTH];
    logic signed [stl_pkg::SAMPLE_W-1:0]   low_mark_reg, high_mark_reg;
    logic signed [stl_pkg::APPLIED_W-1:0]  last_applied_reg;

    // output register
    logic                                  m_valid_reg;
    logic signed [stl_pkg::APPLIED_W-1:0]  m_applied_reg;
    logic                                  m_limited_reg;
    logic signed [stl_pkg::SAMPLE_W-1:0]   m_meas_reg, m_min_reg, m_max_reg;

    // stage movement: frames leave s2 without touching the output register
    logic s2_commit, s2_take, s1_take, s0_take;

    assign s2_commit = s2_valid_reg
                    && (s2_kind_reg == KIND_FRAME || !m_valid_reg || m_tready);
    assign s2_take   = !s2_valid_reg || s2_commit;
    assign s1_take   = !s1_valid_reg || s2_take;
    assign s0_take   = !s0_valid_reg || s1_take;
    assign s_tready  = s0_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            // rejected frames are taken and dropped here
            if (s0_take) begin
                s0_valid_reg <= s_accept && (in_is_cmd || in_frame_ok);
            end
            if (s1_take) begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (s2_take) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // s0 -> s1: torque times eps_factor
    // ---------------------------------------------------------------
    logic signed [stl_pkg::PROD_W-1:0] prod_next;

    assign prod_next = stl_pkg::PROD_W'(s0_torque_reg)
                     * $signed({1'b0, eps_factor_reg});

    always_ff @(posedge aclk) begin
        if (s0_take) begin
            s0_kind_reg   <= in_is_cmd ? KIND_CMD : KIND_FRAME;
            s0_torque_reg <= in_torque;
            s0_cmd_reg    <= in_command;
        end
        if (s1_take) begin
            s1_kind_reg <= s0_kind_reg;
            s1_prod_reg <= prod_next;
            s1_cmd_reg  <= s0_cmd_reg;
        end
    end

    // ---------------------------------------------------------------
    // s1 -> s2: divide by 100 (frames), measured-torque clamp (commands)
    // ---------------------------------------------------------------
    logic                                  prod_neg;
    logic [stl_pkg::PROD_W-1:0]            prod_abs;
    logic [stl_pkg::MAG_W-1:0]             prod_mag;
    logic [stl_pkg::MAG_W+stl_pkg::RECIP_W-1:0] recip_prod;
    logic [stl_pkg::QUOT_W-1:0]            quot;
    logic signed [stl_pkg::SAMPLE_W-1:0]   sample_next;

    // truncation toward zero: divide the magnitude, then restore the sign
    assign prod_neg    = s1_prod_reg[stl_pkg::PROD_W-1];
    assign prod_abs    = prod_neg ? stl_pkg::PROD_W'(-s1_prod_reg)
                                  : stl_pkg::PROD_W'(s1_prod_reg);
    assign prod_mag    = prod_abs[stl_pkg::MAG_W-1:0];
    assign recip_prod  = (stl_pkg::MAG_W + stl_pkg::RECIP_W)'(prod_mag)
                       * (stl_pkg::MAG_W + stl_pkg::RECIP_W)'(stl_pkg::RECIP_100);
    assign quot        = recip_prod[stl_pkg::RECIP_SHIFT +: stl_pkg::QUOT_W];
    assign sample_next = prod_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

    // newest sample as a command in s1 sees it: a frame committing from s2 wins
    logic signed [stl_pkg::SAMPLE_W-1:0] meas_src;
    calc_t meas_w, err_w, lim_w, cmd1_w;
    calc_t meas_lower, meas_upper, clamp1;

    assign meas_src = (s2_valid_reg && s2_kind_reg == KIND_FRAME) ? s2_sample_reg
                                                                  : window_reg[0];

    always_comb begin
        meas_w     = CW'(meas_src) <<< F;
        err_w      = calc_t'(CW'(error_limit_reg)) <<< F;
        lim_w      = calc_t'(CW'(torque_limit_reg)) <<< F;
        cmd1_w     = CW'(s1_cmd_reg);
        meas_lower = smax(smin(meas_w - err_w, -err_w), -lim_w);
        meas_upper = smin(smax(meas_w + err_w, err_w), lim_w);
        clamp1     = smax(meas_lower, smin(cmd1_w, meas_upper));
    end

    always_ff @(posedge aclk) begin
        if (s2_take) begin
            s2_kind_reg   <= s1_kind_reg;
            s2_sample_reg <= sample_next;
            s2_val_reg    <= clamp1;
            s2_cmd_reg    <= s1_cmd_reg;
        end
    end

    // ---------------------------------------------------------------
    // s2 commit: rate limit, rounding, window update
    // ---------------------------------------------------------------
    calc_t last_w, up_w, down_w, rate_lower, rate_upper, clamp2;
    logic                                  v_neg;
    logic [CW-1:0]                         v_mag, r_mag;
    calc_t                                 r_w, back_w, cmd2_w;
    logic signed [stl_pkg::APPLIED_W-1:0]  applied;
    logic                                  limited;

    always_comb begin
        last_w = CW'(last_applied_reg) <<< F;
        up_w   = calc_t'(CW'(rate_up_reg)) <<< F;
        down_w = calc_t'(CW'(rate_down_reg)) <<< F;
        // moving away from zero is held to rate_up, toward zero to rate_down
        if (last_w > 0) begin
            rate_lower = smax(last_w - down_w, -up_w);
            rate_upper = last_w + up_w;
        end else begin
            rate_lower = last_w - up_w;
            rate_upper = smin(last_w + down_w, up_w);
        end
        clamp2 = smax(rate_lower, smin(s2_val_reg, rate_upper));
        // round half away from zero
        v_neg  = clamp2[CW-1];
        v_mag  = v_neg ? CW'(-clamp2) : CW'(clamp2);
        r_mag  = (v_mag + HALF) >> F;
        r_w    = v_neg ? -$signed(r_mag) : $signed(r_mag);
        applied = r_w[stl_pkg::APPLIED_W-1:0];
        // flag compares at full command precision
        back_w  = CW'(applied) <<< F;
        cmd2_w  = CW'(s2_cmd_reg);
        limited = (back_w != cmd2_w);
    end

    // new window contents and its extremes
    logic signed [stl_pkg::SAMPLE_W-1:0] win_next [stl_pkg::WINDOW_DEPTH];
    logic signed [stl_pkg::SAMPLE_W-1:0] win_min, win_max;

    always_comb begin
        win_next[0] = s2_sample_reg;
        for (int i = 1; i < stl_pkg::WINDOW_DEPTH; i++) begin
            win_next[i] = window_reg[i-1];
        end
        win_min = win_next[0];
        win_max = win_next[0];
        for (int i = 1; i < stl_pkg::WINDOW_DEPTH; i++) begin
            if (win_next[i] < win_min) begin
                win_min = win_next[i];
            end
            if (win_next[i] > win_max) begin
                win_max = win_next[i];
            end
        end
    end

    logic commit_frame, commit_cmd;
    assign commit_frame = s2_commit && (s2_kind_reg == KIND_FRAME);
    assign commit_cmd   = s2_commit && (s2_kind_reg == KIND_CMD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < stl_pkg::WINDOW_DEPTH; i++) begin
                window_reg[i] <= '0;
            end
            low_mark_reg     <= '0;
            high_mark_reg    <= '0;
            last_applied_reg <= '0;
        end else begin
            if (commit_frame) begin
                for (int i = 0; i < stl_pkg::WINDOW_DEPTH; i++) begin
                    window_reg[i] <= win_next[i];
                end
                low_mark_reg  <= win_min - stl_pkg::SAMPLE_W'(1);
                high_mark_reg <= win_max + stl_pkg::SAMPLE_W'(1);
            end
            if (commit_cmd) begin
                last_applied_reg <= applied;
            end
        end
    end

    // ---------------------------------------------------------------
    // output register: holds a result until taken, frees as it goes
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit_cmd) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit_cmd) begin
            m_applied_reg <= applied;
            m_limited_reg <= limited;
            m_meas_reg    <= window_reg[0];
            m_min_reg     <= low_mark_reg;
            m_max_reg     <= high_mark_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_limited_reg;
    assign m_tdata  = {{(stl_pkg::M_TDATA_W - stl_pkg::M_USED_W){1'b0}},
                       m_max_reg, m_min_reg, m_meas_reg, m_applied_reg};

endmodule

[design/stl_checker.sv]
// stl_checker: port-level assertions for steering_torque_limiter_core
// attached to the top level by the bind statement at the end of this file
// depends on stl_pkg
module stl_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [stl_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                    m_tuser
);

    logic signed [stl_pkg::APPLIED_W-1:0] applied;
    logic signed [stl_pkg::SAMPLE_W-1:0]  meas, wmin, wmax;

    assign applied = m_tdata[stl_pkg::M_MEAS_LSB-1:stl_pkg::M_APPLIED_LSB];
    assign meas    = m_tdata[stl_pkg::M_MIN_LSB-1:stl_pkg::M_MEAS_LSB];
    assign wmin    = m_tdata[stl_pkg::M_MAX_LSB-1:stl_pkg::M_MIN_LSB];
    assign wmax    = m_tdata[stl_pkg::M_USED_W-1:stl_pkg::M_MAX_LSB];

    // no result survives a reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // newest sample lies between the window marks
    a_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (wmin <= meas) && (meas <= wmax))
        else $error("measured torque outside window marks");

    // applied torque never reaches the most negative code
    a_applied_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> applied != {1'b1, {(stl_pkg::APPLIED_W-1){1'b0}}})
        else $error("applied torque out of range");

endmodule

bind steering_torque_limiter_core stl_checker u_stl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/tb_steering_torque_limiter_core.sv]
// self-checking testbench for steering_torque_limiter_core: stream traffic of measurement
// frames and torque commands, checked against an in-bench predictor of window and clamp
// depends on stl_pkg and the core rtl
module tb_steering_torque_limiter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CLK_PERIOD    = 10;
    // watchdog bound on the whole run, set with heavy idling in mind
    localparam int     CYCLE_LIMIT   = 200000;
    localparam int     DRAIN_LIMIT   = 20000;
    // settle time after the drain so frames still in the pipeline have landed
    localparam int     SETTLE_CYCLES = 8;
    localparam int     STALL_CYCLES  = 300;
    localparam longint CMD_ONE       = longint'(1) << stl_pkg::CMD_FRAC_BITS;
    localparam longint CMD_MAX       = (longint'(1) << (stl_pkg::CMD_W - 1)) - 1;
    localparam longint CMD_MIN       = -(longint'(1) << (stl_pkg::CMD_W - 1));

    // one input item, before packing
    typedef struct {
        logic                                 op;
        logic [stl_pkg::FRAME_ID_W-1:0]       frame_id;
        logic [stl_pkg::BUS_W-1:0]            bus;
        logic [stl_pkg::LEN_W-1:0]            len;
        logic [stl_pkg::TORQUE_W-1:0]         torque_raw;
        logic signed [stl_pkg::CMD_W-1:0]     command;
    } torque_item_t;

    // one predicted result item
    typedef struct {
        logic signed [stl_pkg::APPLIED_W-1:0] applied;
        logic                                 limited;
        logic signed [stl_pkg::SAMPLE_W-1:0]  measured;
        logic signed [stl_pkg::SAMPLE_W-1:0]  win_low;
        logic signed [stl_pkg::SAMPLE_W-1:0]  win_high;
    } torque_result_t;

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    // frame_id, bus_index, data_length, torque_raw, command, zero pad
    logic [stl_pkg::S_TDATA_W-1:0]   s_tdata     = '0;
    // operation
    logic [0:0]                      s_tuser     = '0;
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    // applied_torque, measured_torque, window_min, window_max, zero pad
    logic [stl_pkg::M_TDATA_W-1:0]   m_tdata;
    // limited
    logic [0:0]                      m_tuser;
    logic                            cfg_wr_en   = 1'b0;
    logic [stl_pkg::CFG_ADDR_W-1:0]  cfg_addr    = '0;
    logic [stl_pkg::CFG_DATA_W-1:0]  cfg_wr_data = '0;

    // predictor copy of the limit registers
    logic [stl_pkg::EPS_W-1:0]       eps_factor   = stl_pkg::EPS_FACTOR_RST;
    logic [stl_pkg::RATE_W-1:0]      rate_up      = stl_pkg::RATE_UP_RST;
    logic [stl_pkg::RATE_W-1:0]      rate_down    = stl_pkg::RATE_DOWN_RST;
    logic [stl_pkg::LIMIT_W-1:0]     error_limit  = stl_pkg::ERROR_LIMIT_RST;
    logic [stl_pkg::LIMIT_W-1:0]     torque_limit = stl_pkg::TORQUE_LIMIT_RST;

    // predictor copy of the window, marks and last applied torque
    logic signed [stl_pkg::SAMPLE_W-1:0]  samples[stl_pkg::WINDOW_DEPTH] = '{default: '0};
    logic signed [stl_pkg::SAMPLE_W-1:0]  low_mark     = '0;
    logic signed [stl_pkg::SAMPLE_W-1:0]  high_mark    = '0;
    logic signed [stl_pkg::APPLIED_W-1:0] last_applied = '0;

    // applied torque results still owed by the core, oldest first
    torque_result_t pending_torque[$];

    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned src_idle_pct  = 33;
    int unsigned rx_idle_pct   = 87;
    // long output stalls: test side bumps requests, monitor serves them
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;
    int unsigned hold_left     = 0;

    steering_torque_limiter_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // hard stop if the core hangs
    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic longint min_of(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint max_of(longint a, longint b);
        return (a > b) ? a : b;
    endfunction

    // upper bound applied first, lower bound wins when the two cross
    function automatic longint clamp(longint v, longint lower, longint upper);
        return max_of(lower, min_of(v, upper));
    endfunction

    // scale a measured sample, shift it into the window, refresh the marks
    function automatic void push_sample(logic [stl_pkg::TORQUE_W-1:0] raw);
        longint t;
        longint s;
        longint lo;
        longint hi;
        t = longint'($signed(raw));
        // signed division truncates toward zero
        s = (t * longint'(eps_factor)) / 100;
        for (int i = stl_pkg::WINDOW_DEPTH - 1; i > 0; i--) samples[i] = samples[i - 1];
        samples[0] = stl_pkg::SAMPLE_W'(s);
        lo = s;
        hi = s;
        for (int i = 1; i < stl_pkg::WINDOW_DEPTH; i++) begin
            lo = min_of(lo, samples[i]);
            hi = max_of(hi, samples[i]);
        end
        low_mark  = stl_pkg::SAMPLE_W'(lo - 1);
        high_mark = stl_pkg::SAMPLE_W'(hi + 1);
    endfunction

    // clamp a command around the newest sample and the torque limit, rate limit it
    // against the last applied value, round half away from zero
    function automatic torque_result_t limit_command(logic signed [stl_pkg::CMD_W-1:0] cmd_in);
        torque_result_t res;
        longint cmd;
        longint meas;
        longint err;
        longint lim;
        longint up;
        longint down;
        longint last;
        longint v;
        longint r;
        cmd  = cmd_in;
        meas = longint'(samples[0]) * CMD_ONE;
        err  = longint'(error_limit) * CMD_ONE;
        lim  = longint'(torque_limit) * CMD_ONE;
        up   = longint'(rate_up) * CMD_ONE;
        down = longint'(rate_down) * CMD_ONE;
        last = longint'(last_applied) * CMD_ONE;
        v = clamp(cmd, max_of(min_of(meas - err, -err), -lim),
                  min_of(max_of(meas + err, err), lim));
        if (last > 0) begin
            v = clamp(v, max_of(last - down, -up), last + up);
        end else begin
            v = clamp(v, last - up, min_of(last + down, up));
        end
        if (v >= 0) begin
            r = (v + CMD_ONE / 2) / CMD_ONE;
        end else begin
            r = -((-v + CMD_ONE / 2) / CMD_ONE);
        end
        last_applied = stl_pkg::APPLIED_W'(r);
        res.applied  = stl_pkg::APPLIED_W'(r);
        // flag compares at full command precision
        res.limited  = (r * CMD_ONE != cmd);
        res.measured = samples[0];
        res.win_low  = low_mark;
        res.win_high = high_mark;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------

    function automatic longint spread(longint span);
        return longint'($urandom_range(2 * span, 0)) - span;
    endfunction

    // unused command field gets random bits
    function automatic torque_item_t make_frame(logic [stl_pkg::FRAME_ID_W-1:0] id,
                                                logic [stl_pkg::BUS_W-1:0] bus,
                                                logic [stl_pkg::LEN_W-1:0] len,
                                                logic [stl_pkg::TORQUE_W-1:0] raw);
        torque_item_t it;
        it.op         = stl_pkg::OP_FRAME;
        it.frame_id   = id;
        it.bus        = bus;
        it.len        = len;
        it.torque_raw = raw;
        it.command    = stl_pkg::CMD_W'($urandom);
        return it;
    endfunction

    // unused frame fields get random bits
    function automatic torque_item_t make_command(longint value);
        torque_item_t it;
        it.op         = stl_pkg::OP_COMMAND;
        it.frame_id   = stl_pkg::FRAME_ID_W'($urandom);
        it.bus        = stl_pkg::BUS_W'($urandom);
        it.len        = stl_pkg::LEN_W'($urandom_range(8, 0));
        it.torque_raw = stl_pkg::TORQUE_W'($urandom);
        it.command    = value[stl_pkg::CMD_W-1:0];
        return it;
    endfunction

    // mostly good frames and commands near the live state, some broken frames and
    // full-range noise
    function automatic torque_item_t random_item();
        int unsigned pick;
        logic [stl_pkg::FRAME_ID_W-1:0] id;
        logic [stl_pkg::BUS_W-1:0] bus;
        logic [stl_pkg::LEN_W-1:0] len;
        logic [stl_pkg::TORQUE_W-1:0] raw;
        longint last_cmd;
        longint meas_cmd;
        pick     = $urandom_range(99, 0);
        last_cmd = longint'(last_applied) * CMD_ONE;
        meas_cmd = longint'(samples[0]) * CMD_ONE;
        if ($urandom_range(1, 0) == 0) begin
            raw = stl_pkg::TORQUE_W'($urandom);
        end else begin
            raw = stl_pkg::TORQUE_W'(spread(3000));
        end
        if (pick < 30) begin
            return make_frame(stl_pkg::FRAME_ID_MATCH, stl_pkg::BUS_MATCH,
                              stl_pkg::LEN_MATCH, raw);
        end
        if (pick < 38) begin
            // exactly one of id, bus, length wrong
            id  = stl_pkg::FRAME_ID_MATCH;
            bus = stl_pkg::BUS_MATCH;
            len = stl_pkg::LEN_MATCH;
            case ($urandom_range(2, 0))
                0: id = stl_pkg::FRAME_ID_W'($urandom);
                1: bus = stl_pkg::BUS_W'($urandom_range(7, 1));
                default: len = stl_pkg::LEN_W'($urandom_range(7, 0));
            endcase
            return make_frame(id, bus, len, raw);
        end
        if (pick < 50) return make_command($urandom);
        // whole-unit steps around the last output, can come out unflagged
        if (pick < 62) return make_command(last_cmd + CMD_ONE * spread(5));
        if (pick < 72) return make_command(last_cmd + spread(48));
        if (pick < 80) return make_command(last_cmd + spread(3000));
        return make_command(meas_cmd + spread(longint'(error_limit) * CMD_ONE + 64));
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one item, predict on the accepting edge; valid stays up for a
    // following item unless the idle draw drops it
    task automatic send_item(torque_item_t it);
        logic [stl_pkg::S_TDATA_W-1:0] data;
        torque_result_t res;
        data = '0;
        data[stl_pkg::S_ID_LSB +: stl_pkg::FRAME_ID_W]   = it.frame_id;
        data[stl_pkg::S_BUS_LSB +: stl_pkg::BUS_W]       = it.bus;
        data[stl_pkg::S_LEN_LSB +: stl_pkg::LEN_W]       = it.len;
        data[stl_pkg::S_TORQUE_LSB +: stl_pkg::TORQUE_W] = it.torque_raw;
        data[stl_pkg::S_CMD_LSB +: stl_pkg::CMD_W]       = it.command;
        while ($urandom_range(99, 0) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        if (it.op == stl_pkg::OP_COMMAND) begin
            res = limit_command(it.command);
            pending_torque.insert(pending_torque.size(), res);
        end else if (it.frame_id == stl_pkg::FRAME_ID_MATCH && it.bus == stl_pkg::BUS_MATCH &&
                     it.len == stl_pkg::LEN_MATCH) begin
            push_sample(it.torque_raw);
        end
    endtask

    // leading edge keeps back-to-back writes from toggling enable in one step
    task automatic write_reg(logic [stl_pkg::CFG_ADDR_W-1:0] idx, int unsigned value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value[stl_pkg::CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        case (idx)
            stl_pkg::REG_EPS_FACTOR:   eps_factor   = value[stl_pkg::EPS_W-1:0];
            stl_pkg::REG_RATE_UP:      rate_up      = value[stl_pkg::RATE_W-1:0];
            stl_pkg::REG_RATE_DOWN:    rate_down    = value[stl_pkg::RATE_W-1:0];
            stl_pkg::REG_ERROR_LIMIT:  error_limit  = value[stl_pkg::LIMIT_W-1:0];
            stl_pkg::REG_TORQUE_LIMIT: torque_limit = value[stl_pkg::LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(int unsigned eps, int unsigned up, int unsigned down,
                              int unsigned err, int unsigned lim);
        write_reg(stl_pkg::REG_EPS_FACTOR, eps);
        write_reg(stl_pkg::REG_RATE_UP, up);
        write_reg(stl_pkg::REG_RATE_DOWN, down);
        write_reg(stl_pkg::REG_ERROR_LIMIT, err);
        write_reg(stl_pkg::REG_TORQUE_LIMIT, lim);
    endtask

    // drop valid, wait out owed results, then let trailing frames settle
    task automatic wait_idle();
        int unsigned waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_torque.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // result monitor and output flow control
    // ------------------------------------------------------------------

    task automatic check_field(string name, logic signed [63:0] want,
                               logic signed [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        torque_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_torque.size() == 0) begin
                $display("%0t: result item with no command owed, expected none, actual %h/%b",
                         $time, m_tdata, m_tuser);
                error_count++;
            end else begin
                want = pending_torque.pop_front();
                check_field("applied_torque", want.applied,
                            $signed(m_tdata[stl_pkg::M_APPLIED_LSB +: stl_pkg::APPLIED_W]));
                check_field("limited", want.limited, m_tuser[0]);
                check_field("measured_torque", want.measured,
                            $signed(m_tdata[stl_pkg::M_MEAS_LSB +: stl_pkg::SAMPLE_W]));
                check_field("window_min", want.win_low,
                            $signed(m_tdata[stl_pkg::M_MIN_LSB +: stl_pkg::SAMPLE_W]));
                check_field("window_max", want.win_high,
                            $signed(m_tdata[stl_pkg::M_MAX_LSB +: stl_pkg::SAMPLE_W]));
            end
        end
        // a pending hold request turns into a long stretch of ready low
        if (hold_served != hold_requests) begin
            hold_left = STALL_CYCLES;
            hold_served++;
        end
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // default limits: empty window, rounding, command extremes, rejected and
    // accepted frames, sample scaling extremes
    task automatic test_directed_cases();
        // empty window, marks at zero
        send_item(make_command(0));
        // 1.5 rounds up to 2 and is flagged
        send_item(make_command(24));
        // -0.5 rounds away from zero
        send_item(make_command(-8));
        send_item(make_command(CMD_MAX));
        send_item(make_command(CMD_MIN));
        // rejected frames must leave the window alone
        send_item(make_frame(stl_pkg::FRAME_ID_MATCH ^ 11'h1, stl_pkg::BUS_MATCH,
                             stl_pkg::LEN_MATCH, 16'h7fff));
        send_item(make_frame(stl_pkg::FRAME_ID_MATCH, 3'd7, stl_pkg::LEN_MATCH, 16'h7fff));
        send_item(make_frame(stl_pkg::FRAME_ID_MATCH, stl_pkg::BUS_MATCH, 4'd7, 16'h7fff));
        send_item(make_frame(11'h7ff, 3'd4, 4'd0, 16'h8000));
        send_item(make_command(48));
        // accepted frames at the torque extremes
        send_item(make_frame(stl_pkg::FRAME_ID_MATCH, stl_pkg::BUS_MATCH,
                             stl_pkg::LEN_MATCH, 16'h7fff));
        send_item(make_command(CMD_MAX));
        send_item(make_frame(stl_pkg::FRAME_ID_MATCH, stl_pkg::BUS_MATCH,
                             stl_pkg::LEN_MATCH, 16'h8000));
        send_item(make_command(CMD_MIN));
        // -1 truncates to zero, -100 to -73
        send_item(make_frame(stl_pkg::FRAME_ID_MATCH, stl_pkg::BUS_MATCH,
                             stl_pkg::LEN_MATCH, 16'hffff));
        send_item(make_frame(stl_pkg::FRAME_ID_MATCH, stl_pkg::BUS_MATCH,
                             stl_pkg::LEN_MATCH, 16'hff9c));
        send_item(make_frame(stl_pkg::FRAME_ID_MATCH, stl_pkg::BUS_MATCH,
                             stl_pkg::LEN_MATCH, 16'h0001));
        send_item(make_command(-16 * 50));
        // exact repeat of the last output, no flag expected
        send_item(make_command(longint'(last_applied) * CMD_ONE));
        send_item(make_command(longint'(samples[0]) * CMD_ONE + 7));
        wait_idle();
    endtask

    // register corners, each followed by a burst of traffic
    task automatic test_register_extremes();
        // eps factor, rate up, rate down, error limit, torque limit
        int unsigned corners[5][5] = '{
            '{0,   0,    0,    0,     0},
            '{255, 4095, 4095, 32767, 32767},
            '{255, 4095, 0,    0,     32767},
            '{100, 1,    4095, 32767, 0},
            '{73,  10,   20,   350,   1500}
        };
        foreach (corners[k]) begin
            set_limits(corners[k][0], corners[k][1], corners[k][2], corners[k][3],
                       corners[k][4]);
            repeat (16) send_item(random_item());
            wait_idle();
        end
    endtask

    // bulk random traffic under each idle pattern, fresh limits per phase
    task automatic test_random_traffic();
        // sender idle percent, receiver idle percent
        int unsigned idle_plan[3][2] = '{'{33, 87}, '{87, 33}, '{0, 0}};
        foreach (idle_plan[p]) begin
            src_idle_pct = idle_plan[p][0];
            rx_idle_pct  = idle_plan[p][1];
            set_limits($urandom_range(255, 0), $urandom_range(600, 1),
                       $urandom_range(600, 1), $urandom_range(4000, 0),
                       $urandom_range(6000, 0));
            repeat (110) send_item(random_item());
            wait_idle();
        end
    endtask

    // long output hold while the sender keeps pushing, so the pipeline fills
    // and input ready has to drop
    task automatic test_output_stall();
        src_idle_pct = 0;
        rx_idle_pct  = 0;
        hold_requests++;
        repeat (40) send_item(random_item());
        wait_idle();
    endtask

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_register_extremes();
        test_random_traffic();
        test_output_stall();
        wait_idle();
        if (pending_torque.size() != 0) begin
            $display("%0t: results never arrived, expected %0d more, actual 0", $time,
                     pending_torque.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
